[src/scaled_minute_clock_top_macros.svh]
// scaled_minute_clock_top_macros.svh: assertion macros for the scaled minute clock
// used by modules that check their own state; expects clk and rst in scope
`ifndef SCALED_MINUTE_CLOCK_TOP_MACROS_SVH
`define SCALED_MINUTE_CLOCK_TOP_MACROS_SVH

// same-cycle implication
`define SMC_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SMC_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/smc_pkg.sv]
// smc_pkg: types, request codes and constants of the scaled minute clock
// no dependencies; used by every module of the block
package smc_pkg;

  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int PIPE_DEPTH = 8;

  localparam logic [39:0] MAX_MINUTE   = 40'hFF_FFFF_FFFF;
  localparam logic [10:0] MAX_MULT     = 11'd1024;
  localparam logic [15:0] MS_PER_MIN   = 16'd60000;
  localparam logic [10:0] MIN_PER_HOUR = 11'd60;
  localparam logic [10:0] MIN_PER_DAY  = 11'd1440;

  // 60000 = 1875 << 5: divide the shifted value by 1875 via a reciprocal
  localparam int          MS_SHIFT     = 5;
  localparam logic [10:0] MS_ODD       = 11'd1875;
  // floor(2^38 / 1875) for 27-bit dividends
  localparam logic [27:0] RECIP_A      = 28'd146601550;
  // floor(2^32 / 1875) for 21-bit dividends
  localparam logic [21:0] RECIP_B      = 22'd2290649;

  typedef enum logic [2:0] {
    REQ_ADVANCE   = 3'd0,
    REQ_STEP_MIN  = 3'd1,
    REQ_STEP_HOUR = 3'd2,
    REQ_STEP_DAY  = 3'd3,
    REQ_LOAD      = 3'd4
  } req_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] amount;
    logic [40:0] start_minute;
  } req_item_t;

  typedef struct packed {
    logic [39:0] applied_minutes;
    logic [39:0] current_minute;
    logic        clamped_flag;
  } rsp_item_t;

  typedef struct packed {
    logic [10:0] multiplier;
    logic        paused;
    logic [31:0] max_step_minutes;
    logic [31:0] max_step_hours;
    logic [31:0] max_step_days;
  } cfg_t;

  // one pipeline slot; q and r are reused by both division passes
  typedef struct packed {
    logic [2:0]  req;
    logic [31:0] amount;
    logic [40:0] start;
    logic        step_ok;
    logic [16:0] q;
    logic [11:0] r;
    logic [26:0] qm;
    logic [25:0] pm;
    logic [42:0] mins;
    logic [42:0] mins_p1;
    logic [15:0] rem;
  } stage_t;

endpackage

[src/smc_cfg.sv]
// smc_cfg: apb register file of the scaled minute clock
// depends on smc_pkg
module smc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [smc_pkg::ADDR_W-1:0]  paddr,
  input  logic [smc_pkg::DATA_W-1:0]  pwdata,
  output logic [smc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output smc_pkg::cfg_t               cfg
);

  typedef enum logic [2:0] {
    REG_MULT     = 3'd0,
    REG_PAUSED   = 3'd1,
    REG_MAX_MIN  = 3'd2,
    REG_MAX_HOUR = 3'd3,
    REG_MAX_DAY  = 3'd4
  } reg_idx_t;

  logic [2:0] idx;
  logic       wr;
  logic       mult_ok;

  assign pready  = 1'b1;
  assign idx     = paddr[4:2];
  assign wr      = psel && penable && pwrite;
  assign mult_ok = (pwdata[10:0] != 11'd0) && (pwdata[10:0] <= smc_pkg::MAX_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.multiplier       <= 11'd1;
      cfg.paused           <= 1'b0;
      cfg.max_step_minutes <= 32'd1440;
      cfg.max_step_hours   <= 32'd168;
      cfg.max_step_days    <= 32'd365;
    end else if (wr) begin
      case (idx)
        REG_MULT: begin
          if (mult_ok) cfg.multiplier <= pwdata[10:0];
        end
        REG_PAUSED:   cfg.paused           <= pwdata[0];
        REG_MAX_MIN:  cfg.max_step_minutes <= pwdata;
        REG_MAX_HOUR: cfg.max_step_hours   <= pwdata;
        REG_MAX_DAY:  cfg.max_step_days    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MULT:     prdata = {21'd0, cfg.multiplier};
      REG_PAUSED:   prdata = {31'd0, cfg.paused};
      REG_MAX_MIN:  prdata = cfg.max_step_minutes;
      REG_MAX_HOUR: prdata = cfg.max_step_hours;
      REG_MAX_DAY:  prdata = cfg.max_step_days;
      default:      prdata = '0;
    endcase
  end

endmodule

[src/smc_pipe.sv]
// smc_pipe: state-free front pipeline; step limit check and step scaling,
// and split of amount * multiplier into whole minutes and leftover ms
// depends on smc_pkg
module smc_pipe (
  input  logic                clk,
  input  logic                rst,
  input  smc_pkg::cfg_t       cfg,
  input  logic                req_valid,
  output logic                req_stall,
  input  smc_pkg::req_item_t  req_data,
  output logic                item_valid,
  input  logic                item_ready,
  output smc_pkg::stage_t     item
);

  localparam int D = smc_pkg::PIPE_DEPTH;

  smc_pkg::stage_t st      [D];
  smc_pkg::stage_t st_next [D];
  logic [D-1:0]    vld;
  logic [D-1:0]    vld_in;
  logic [D:0]      en;

  // stage scratch
  logic [26:0] x_a;
  logic [54:0] prod_a;
  logic [31:0] lim_a;
  logic [26:0] back_b;
  logic [26:0] diff_b;
  logic [10:0] scale_b;
  logic [42:0] prod_s;
  logic [15:0] ra_d;
  logic [27:0] qm_d;
  logic [26:0] pm_d;
  logic [20:0] y_e;
  logic [42:0] prod_e;
  logic [20:0] y_f;
  logic [20:0] back_f;
  logic [20:0] diff_f;
  logic [9:0]  q2_g;
  logic [11:0] r2_g;
  logic [42:0] mins_g;

  // a slot advances when it is empty or its successor advances
  always_comb begin
    en[D] = item_ready;
    for (int k = D - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign vld_in     = {vld[D-2:0], req_valid};
  assign req_stall  = !en[0];
  assign item_valid = vld[D-1];
  assign item       = st[D-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < D; k++) begin
        if (en[k]) vld[k] <= vld_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < D; k++) begin
      if (en[k]) st[k] <= st_next[k];
    end
  end

  // input register
  always_comb begin
    st_next[0]       = '0;
    st_next[0].req   = req_data.req_type;
    st_next[0].amount = req_data.amount;
    st_next[0].start = req_data.start_minute;
  end

  // quotient estimate of (amount >> 5) / 1875, step limit check
  assign x_a    = st[0].amount[31:smc_pkg::MS_SHIFT];
  assign prod_a = {28'd0, x_a} * {27'd0, smc_pkg::RECIP_A};

  always_comb begin
    case (st[0].req)
      smc_pkg::REQ_STEP_MIN:  lim_a = cfg.max_step_minutes;
      smc_pkg::REQ_STEP_HOUR: lim_a = cfg.max_step_hours;
      smc_pkg::REQ_STEP_DAY:  lim_a = cfg.max_step_days;
      default:                lim_a = '0;
    endcase
    st_next[1]         = st[0];
    st_next[1].q       = prod_a[54:38];
    st_next[1].step_ok = (st[0].amount != 32'd0) && (st[0].amount <= lim_a);
  end

  // remainder of the estimate, step count scaled to minutes
  assign back_b = 27'(st[1].q) * 27'(smc_pkg::MS_ODD);
  assign diff_b = st[1].amount[31:smc_pkg::MS_SHIFT] - back_b;
  assign prod_s = {11'd0, st[1].amount} * {32'd0, scale_b};

  always_comb begin
    case (st[1].req)
      smc_pkg::REQ_STEP_HOUR: scale_b = smc_pkg::MIN_PER_HOUR;
      smc_pkg::REQ_STEP_DAY:  scale_b = smc_pkg::MIN_PER_DAY;
      default:                scale_b = 11'd1;
    endcase
    st_next[2]      = st[1];
    st_next[2].r    = diff_b[11:0];
    st_next[2].mins = prod_s;
  end

  // estimate is at most one low
  always_comb begin
    st_next[3] = st[2];
    if (st[2].r >= 12'(smc_pkg::MS_ODD)) begin
      st_next[3].q = st[2].q + 17'd1;
      st_next[3].r = st[2].r - 12'(smc_pkg::MS_ODD);
    end
  end

  // scale whole minutes and leftover ms of amount by the multiplier
  assign ra_d = {st[3].r[10:0], st[3].amount[smc_pkg::MS_SHIFT-1:0]};
  assign qm_d = {11'd0, st[3].q} * {17'd0, cfg.multiplier};
  assign pm_d = {11'd0, ra_d} * {16'd0, cfg.multiplier};

  always_comb begin
    st_next[4]    = st[3];
    st_next[4].qm = qm_d[26:0];
    st_next[4].pm = pm_d[25:0];
  end

  // second division pass on the scaled leftover
  assign y_e    = st[4].pm[25:smc_pkg::MS_SHIFT];
  assign prod_e = {22'd0, y_e} * {21'd0, smc_pkg::RECIP_B};

  always_comb begin
    st_next[5]   = st[4];
    st_next[5].q = {7'd0, prod_e[41:32]};
  end

  assign y_f    = st[5].pm[25:smc_pkg::MS_SHIFT];
  assign back_f = {11'd0, st[5].q[9:0]} * {10'd0, smc_pkg::MS_ODD};
  assign diff_f = y_f - back_f;

  always_comb begin
    st_next[6]   = st[5];
    st_next[6].r = diff_f[11:0];
  end

  // correct, then gather minutes and sub-minute ms for an advance
  always_comb begin
    q2_g = st[6].q[9:0];
    r2_g = st[6].r;
    if (st[6].r >= 12'(smc_pkg::MS_ODD)) begin
      q2_g = st[6].q[9:0] + 10'd1;
      r2_g = st[6].r - 12'(smc_pkg::MS_ODD);
    end
    mins_g = 43'(st[6].qm) + 43'(q2_g);
    st_next[7]     = st[6];
    st_next[7].rem = {r2_g[10:0], st[6].pm[smc_pkg::MS_SHIFT-1:0]};
    st_next[7].mins_p1 = st[6].mins;
    if (st[6].req == smc_pkg::REQ_ADVANCE) begin
      st_next[7].mins    = mins_g;
      st_next[7].mins_p1 = mins_g + 43'd1;
    end
  end

endmodule

[src/smc_state.sv]
// smc_state: minute count, ms credit and clamp flag, with the result register
// depends on smc_pkg and scaled_minute_clock_top_macros.svh
`include "scaled_minute_clock_top_macros.svh"

module smc_state (
  input  logic               clk,
  input  logic               rst,
  input  smc_pkg::cfg_t      cfg,
  input  logic               item_valid,
  output logic               item_ready,
  input  smc_pkg::stage_t    item,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output smc_pkg::rsp_item_t rsp_data
);

  logic [39:0] sim_minute;
  logic [15:0] credit;
  logic        clamp_seen;

  logic [39:0] sim_minute_next;
  logic [15:0] credit_next;
  logic        clamp_seen_next;
  logic [39:0] applied;

  logic        take;
  logic        at_ceiling;
  logic [39:0] room;
  logic [16:0] credit_sum;
  logic        carry;
  logic [15:0] credit_adv;
  logic        add_en;
  logic [42:0] add_amt;
  logic        over;
  logic        clamp_hit;

  assign item_ready = !rsp_valid || !rsp_stall;
  assign take       = item_valid && item_ready;
  assign at_ceiling = sim_minute >= smc_pkg::MAX_MINUTE;
  assign room       = smc_pkg::MAX_MINUTE - sim_minute;
  assign credit_sum = {1'b0, credit} + {1'b0, item.rem};
  assign carry      = credit_sum >= {1'b0, smc_pkg::MS_PER_MIN};
  assign credit_adv = carry ? 16'(credit_sum - {1'b0, smc_pkg::MS_PER_MIN}) : credit_sum[15:0];
  assign over       = add_amt > {3'd0, room};
  assign clamp_hit  = add_en && over;

  always_comb begin
    sim_minute_next = sim_minute;
    credit_next     = credit;
    clamp_seen_next = clamp_seen;
    applied         = '0;
    add_en          = 1'b0;
    add_amt         = item.mins;
    case (item.req)
      smc_pkg::REQ_ADVANCE: begin
        if (!cfg.paused && (item.amount != 32'd0) && !at_ceiling) begin
          credit_next = credit_adv;
          add_amt     = carry ? item.mins_p1 : item.mins;
          add_en      = add_amt != 43'd0;
        end
      end
      smc_pkg::REQ_STEP_MIN, smc_pkg::REQ_STEP_HOUR, smc_pkg::REQ_STEP_DAY: begin
        add_en = item.step_ok && !at_ceiling;
      end
      smc_pkg::REQ_LOAD: begin
        credit_next = '0;
        if (item.start > {1'b0, smc_pkg::MAX_MINUTE}) begin
          sim_minute_next = smc_pkg::MAX_MINUTE;
          clamp_seen_next = 1'b1;
        end else begin
          sim_minute_next = item.start[39:0];
          clamp_seen_next = 1'b0;
        end
      end
      default: ;
    endcase
    if (add_en) begin
      if (over) begin
        applied         = room;
        sim_minute_next = smc_pkg::MAX_MINUTE;
        credit_next     = '0;
        clamp_seen_next = 1'b1;
      end else begin
        applied         = add_amt[39:0];
        sim_minute_next = sim_minute + add_amt[39:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sim_minute <= '0;
      credit     <= '0;
      clamp_seen <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (item_ready) rsp_valid <= item_valid;
      if (take) begin
        sim_minute <= sim_minute_next;
        credit     <= credit_next;
        clamp_seen <= clamp_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp_data.applied_minutes <= applied;
      rsp_data.current_minute  <= sim_minute_next;
      rsp_data.clamped_flag    <= clamp_seen_next;
    end
  end

  `SMC_CHECK(credit_below_minute, 1'b1, credit < smc_pkg::MS_PER_MIN, "ms credit reached a minute")
  `SMC_CHECK_NEXT(applied_adds_up, take && (item.req != smc_pkg::REQ_LOAD), rsp_data.current_minute == $past(sim_minute) + rsp_data.applied_minutes, "minute count and applied minutes disagree")
  `SMC_CHECK_NEXT(ceiling_holds, take && at_ceiling && (item.req != smc_pkg::REQ_LOAD), (rsp_data.applied_minutes == 40'd0) && (sim_minute == smc_pkg::MAX_MINUTE), "count moved off the ceiling")
  `SMC_CHECK_NEXT(clamp_clears_credit, take && clamp_hit, (credit == 16'd0) && clamp_seen && rsp_data.clamped_flag, "clamp did not clear credit or set flag")

endmodule

[src/scaled_minute_clock_top.sv]
// scaled_minute_clock_top: top level of the scaled minute clock
// depends on smc_pkg, smc_cfg, smc_pipe and smc_state
//
// usage
// - req channel (req_valid / req_stall / req_data) carries one transaction per
//   request: advance by real ms, step by minutes, hours or days, or load a minute
// - rsp channel (rsp_valid / rsp_stall / rsp_data) returns exactly one
//   transaction per request, in order: minutes applied, minute count after the
//   request and the sticky clamp flag
// - a transaction moves at a rising edge with valid high and stall low
// - throughput: one request per cycle, sustained while rsp_stall stays low
// - path: a taken request passes through the eight-slot front pipeline
//   (two reciprocal divisions by 60000) and then the state update in the
//   result register, which holds the result on rsp_data
// - rsp_stall holds the result register; the front pipeline keeps taking
//   requests until every slot is full, then req_stall rises
// - apb port: registers at byte addresses 0 (multiplier), 4 (paused),
//   8, 12, 16 (step limits); pready is always high; write only while idle
// - reset (rst, synchronous): minute count, credit and clamp flag cleared,
//   registers back to multiplier 1, running, limits 1440 / 168 / 365;
//   no clearing pass, requests are taken from the first cycle after reset
module scaled_minute_clock_top (
  input  logic                        clk,
  input  logic                        rst,
  // request transactions
  input  logic                        req_valid,
  output logic                        req_stall,
  input  smc_pkg::req_item_t          req_data,
  // result transactions
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output smc_pkg::rsp_item_t          rsp_data,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [smc_pkg::ADDR_W-1:0]  paddr,
  input  logic [smc_pkg::DATA_W-1:0]  pwdata,
  output logic [smc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  smc_pkg::cfg_t   cfg;
  smc_pkg::stage_t item;
  logic            item_valid;
  logic            item_ready;

  // register file; the user must keep values stable whenever requests are in flight, the block does not enforce it
  smc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // everything that does not depend on the clock state: limit checks,
  // step scaling and the split of amount * multiplier into minutes and ms
  smc_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  // credit carry, ceiling clamp and load, updated as the result is registered
  smc_state u_state (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp_data   (rsp_data)
  );

endmodule

[tb/scaled_minute_clock_top_tb.sv]
// scaled_minute_clock_top_tb: self-checking bench for the scaled minute clock top level
// depends on smc_pkg and scaled_minute_clock_top; drives requests and apb writes, checks results
module scaled_minute_clock_top_tb;
  import smc_pkg::*;

  // request codes with no meaning, the block must leave its state alone
  localparam logic [2:0] REQ_NONE_LO = 3'd5;
  localparam logic [2:0] REQ_NONE_HI = 3'd7;

  // apb register map, one 32-bit word per register
  localparam logic [ADDR_W-1:0] ADDR_MULT      = 5'd0;
  localparam logic [ADDR_W-1:0] ADDR_PAUSED    = 5'd4;
  localparam logic [ADDR_W-1:0] ADDR_LIM_MIN   = 5'd8;
  localparam logic [ADDR_W-1:0] ADDR_LIM_HOUR  = 5'd12;
  localparam logic [ADDR_W-1:0] ADDR_LIM_DAY   = 5'd16;

  // directed rows either carry a hand-written result or lean on the local clock copy
  localparam bit HAND_CHECKED  = 1'b1;
  localparam bit MODEL_CHECKED = 1'b0;

  localparam int SETTINGS          = 6;
  localparam int ITEMS_PER_SETTING = 250;

  // register settings walked by the random part: reset values, the wide extremes,
  // paused with tight limits, every step refused, an odd rate, and rejected rates
  // (0, 2047 and 1025 must leave the rate as it was)
  localparam cfg_t CFG_PLAN [SETTINGS] = '{
    '{11'd1,    1'b0, 32'd1440,       32'd168,        32'd365},
    '{11'd1024, 1'b0, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF},
    '{11'd0,    1'b1, 32'd1,          32'd1,          32'd1},
    '{11'd2047, 1'b0, 32'd0,          32'd0,          32'd0},
    '{11'd37,   1'b0, 32'd60000,      32'd1000,       32'd100},
    '{11'd1025, 1'b0, 32'd1440,       32'd168,        32'd365}
  };

  // idling per mode: sender gap chance and receiver stall chance, in percent
  localparam int SEND_GAP_PCT [3]   = '{22, 80, 0};
  localparam int RECV_STALL_PCT [3] = '{80, 22, 0};

  typedef struct {
    req_item_t item;
    bit        hand_checked;
    rsp_item_t want;
  } plan_row_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  req_item_t  req_data  = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  rsp_item_t  rsp_data;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // local copy of the clock state and its registers
  logic [39:0] clk_minute  = '0;
  logic [15:0] clk_credit  = '0;
  logic        clk_clamped = 1'b0;
  cfg_t        reg_mirror  = '{11'd1, 1'b0, 32'd1440, 32'd168, 32'd365};

  rsp_item_t awaited_readings [$];

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int error_count     = 0;
  int readings_seen   = 0;
  int ceiling_seen    = 0;
  int n_advance       = 0;
  int n_step          = 0;
  int n_load          = 0;
  int n_undefined     = 0;

  scaled_minute_clock_top uut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // generous cap: the slowest correct run stays far below this
  initial begin
    #2_000_000;
    $display("%0t: run timed out with %0d readings outstanding", $time,
             awaited_readings.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic flag_error(input string what, input logic [63:0] want,
                            input logic [63:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  // adds minutes to the local clock, cut at the ceiling; returns what was applied
  function automatic logic [39:0] credit_minutes(input logic [63:0] minutes);
    logic [63:0] room;
    logic [63:0] used;
    if (minutes == 0 || clk_minute >= MAX_MINUTE) begin
      return '0;
    end
    room = 64'(MAX_MINUTE) - 64'(clk_minute);
    used = (minutes < room) ? minutes : room;
    clk_minute = clk_minute + used[39:0];
    // an exact reach keeps the credit, only a cut clears it
    if (used < minutes) begin
      clk_credit  = '0;
      clk_clamped = 1'b1;
    end
    return used[39:0];
  endfunction

  // moves the local clock on by one request and gives the reading it should produce
  function automatic rsp_item_t next_clock_reading(input req_item_t it);
    logic [63:0] total;
    logic [39:0] applied;
    applied = '0;
    case (it.req_type)
      REQ_ADVANCE: begin
        // paused, zero ms or at the ceiling: nothing moves
        if (!reg_mirror.paused && it.amount != 0 && clk_minute < MAX_MINUTE) begin
          total      = 64'(clk_credit) + 64'(it.amount) * 64'(reg_mirror.multiplier);
          clk_credit = 16'(total % 64'(MS_PER_MIN));
          applied    = credit_minutes(total / 64'(MS_PER_MIN));
        end
      end
      REQ_STEP_MIN: begin
        if (it.amount != 0 && it.amount <= reg_mirror.max_step_minutes) begin
          applied = credit_minutes(64'(it.amount));
        end
      end
      REQ_STEP_HOUR: begin
        if (it.amount != 0 && it.amount <= reg_mirror.max_step_hours) begin
          applied = credit_minutes(64'(it.amount) * 64'(MIN_PER_HOUR));
        end
      end
      REQ_STEP_DAY: begin
        if (it.amount != 0 && it.amount <= reg_mirror.max_step_days) begin
          applied = credit_minutes(64'(it.amount) * 64'(MIN_PER_DAY));
        end
      end
      REQ_LOAD: begin
        // saturate at the ceiling; the clamp flag follows the load alone
        if (it.start_minute > {1'b0, MAX_MINUTE}) begin
          clk_minute  = MAX_MINUTE;
          clk_clamped = 1'b1;
        end else begin
          clk_minute  = it.start_minute[39:0];
          clk_clamped = 1'b0;
        end
        clk_credit = '0;
      end
      default: begin
      end
    endcase
    return '{applied, clk_minute, clk_clamped};
  endfunction

  function automatic plan_row_t plan_row(input logic [2:0] code, input logic [31:0] amount,
                                         input logic [40:0] start, input bit hand,
                                         input logic [39:0] applied,
                                         input logic [39:0] minute, input logic clamp);
    plan_row_t row;
    row.item         = '{code, amount, start};
    row.hand_checked = hand;
    row.want         = '{applied, minute, clamp};
    return row;
  endfunction

  // random request shaped to reach the ceiling often: loads often land close
  // below it, steps mostly sit inside their limit, with boundary and raw values mixed in
  function automatic req_item_t random_request();
    req_item_t   it;
    logic [31:0] lim;
    int          pick;
    pick            = $urandom_range(99);
    it.amount       = $urandom;
    it.start_minute = {9'($urandom), 32'($urandom)};
    if (pick < 35) begin
      it.req_type = REQ_ADVANCE;
      pick = $urandom_range(99);
      if (pick < 5) begin
        it.amount = '0;
      end else if (pick < 80) begin
        it.amount = $urandom_range(1, 300000);
      end
    end else if (pick < 70) begin
      it.req_type = 3'($urandom_range(REQ_STEP_MIN, REQ_STEP_DAY));
      case (it.req_type)
        REQ_STEP_MIN:  lim = reg_mirror.max_step_minutes;
        REQ_STEP_HOUR: lim = reg_mirror.max_step_hours;
        default:       lim = reg_mirror.max_step_days;
      endcase
      pick = $urandom_range(99);
      if (pick < 5) begin
        it.amount = '0;
      end else if (pick < 15) begin
        it.amount = lim + 32'd1;
      end else if (pick < 25) begin
        it.amount = lim;
      end else if (pick < 85) begin
        it.amount = $urandom_range(1, (lim == 0) ? 1 : ((lim < 1000) ? lim : 1000));
      end
    end else if (pick < 95) begin
      it.req_type = REQ_LOAD;
      pick = $urandom_range(99);
      if (pick < 40) begin
        it.start_minute = {1'b0, MAX_MINUTE} - 41'($urandom_range(0, 3000));
      end else if (pick < 55) begin
        it.start_minute = 41'($urandom_range(0, 100000));
      end else if (pick < 70) begin
        it.start_minute = {1'b1, 8'($urandom), 32'($urandom)};
      end else if (pick < 75) begin
        it.start_minute = {1'b0, MAX_MINUTE};
      end
    end else begin
      it.req_type = 3'($urandom_range(REQ_NONE_LO, REQ_NONE_HI));
    end
    return it;
  endfunction

  // offers one request transaction; valid stays up afterwards unless the next call idles
  task automatic send_request(input req_item_t it, input bit hand, input rsp_item_t want);
    rsp_item_t reading;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= it;
    @(posedge clk);
    while (req_stall) begin
      @(posedge clk);
    end
    // taken at this edge: move the local clock on and queue its reading
    reading = next_clock_reading(it);
    awaited_readings.push_back(hand ? want : reading);
    case (it.req_type)
      REQ_ADVANCE:                              n_advance++;
      REQ_STEP_MIN, REQ_STEP_HOUR, REQ_STEP_DAY: n_step++;
      REQ_LOAD:                                 n_load++;
      default:                                  n_undefined++;
    endcase
  endtask

  // apb write: setup cycle then access cycle, the register takes the value at the access edge
  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (addr)
      ADDR_MULT: begin
        // a rate of 0 or above the maximum is refused
        if (data[10:0] != 0 && data[10:0] <= MAX_MULT) begin
          reg_mirror.multiplier = data[10:0];
        end
      end
      ADDR_PAUSED:   reg_mirror.paused           = data[0];
      ADDR_LIM_MIN:  reg_mirror.max_step_minutes = data;
      ADDR_LIM_HOUR: reg_mirror.max_step_hours   = data;
      ADDR_LIM_DAY:  reg_mirror.max_step_days    = data;
      default: begin
      end
    endcase
  endtask

  // apb read, prdata sampled in the access phase
  task automatic cfg_read_check(input logic [ADDR_W-1:0] addr, input logic [31:0] want);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    if (prdata !== want) begin
      flag_error($sformatf("register read at %0d", addr), 64'(want), 64'(prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random stall, and every transaction that moves is compared with
  // the oldest awaited reading; the sampled values are the ones from before the edge
  always @(posedge clk) begin : reading_checker
    rsp_item_t want;
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_readings.size() == 0) begin
        flag_error("unexpected result (current minute)", '0,
                   64'(rsp_data.current_minute));
      end else begin
        want = awaited_readings.pop_front();
        readings_seen++;
        if (want.current_minute == MAX_MINUTE) begin
          ceiling_seen++;
        end
        if (rsp_data.applied_minutes !== want.applied_minutes) begin
          flag_error("applied_minutes", 64'(want.applied_minutes),
                     64'(rsp_data.applied_minutes));
        end
        if (rsp_data.current_minute !== want.current_minute) begin
          flag_error("current_minute", 64'(want.current_minute),
                     64'(rsp_data.current_minute));
        end
        if (rsp_data.clamped_flag !== want.clamped_flag) begin
          flag_error("clamped_flag", 64'(want.clamped_flag), 64'(rsp_data.clamped_flag));
        end
      end
    end
  end

  initial begin
    plan_row_t directed_plan [$];

    // directed rows run on the reset register values:
    // rate 1, running, limits 1440 minutes, 168 hours, 365 days
    directed_plan.push_back(plan_row(REQ_ADVANCE, 32'd0, 41'd0, HAND_CHECKED,
                                     40'd0, 40'd0, 1'b0));       // zero ms is ignored
    directed_plan.push_back(plan_row(REQ_ADVANCE, 32'd60000, 41'd0, HAND_CHECKED,
                                     40'd1, 40'd1, 1'b0));       // one whole minute
    directed_plan.push_back(plan_row(REQ_ADVANCE, 32'd59999, 41'd0, HAND_CHECKED,
                                     40'd0, 40'd1, 1'b0));       // credit just short
    directed_plan.push_back(plan_row(REQ_ADVANCE, 32'd1, 41'd0, HAND_CHECKED,
                                     40'd1, 40'd2, 1'b0));       // credit carries over
    directed_plan.push_back(plan_row(REQ_STEP_MIN, 32'd0, 41'd0, HAND_CHECKED,
                                     40'd0, 40'd2, 1'b0));       // zero count refused
    directed_plan.push_back(plan_row(REQ_STEP_MIN, 32'd1441, 41'd0, HAND_CHECKED,
                                     40'd0, 40'd2, 1'b0));       // one over the limit
    directed_plan.push_back(plan_row(REQ_STEP_MIN, 32'd1440, 41'd0, HAND_CHECKED,
                                     40'd1440, 40'd1442, 1'b0));
    directed_plan.push_back(plan_row(REQ_STEP_HOUR, 32'd169, 41'd0, HAND_CHECKED,
                                     40'd0, 40'd1442, 1'b0));
    directed_plan.push_back(plan_row(REQ_STEP_HOUR, 32'd168, 41'd0, HAND_CHECKED,
                                     40'd10080, 40'd11522, 1'b0));
    directed_plan.push_back(plan_row(REQ_STEP_DAY, 32'd366, 41'd0, HAND_CHECKED,
                                     40'd0, 40'd11522, 1'b0));
    directed_plan.push_back(plan_row(REQ_STEP_DAY, 32'd365, 41'd0, HAND_CHECKED,
                                     40'd525600, 40'd537122, 1'b0));
    directed_plan.push_back(plan_row(REQ_NONE_LO, '1, '1, HAND_CHECKED,
                                     40'd0, 40'd537122, 1'b0));  // undefined codes
    directed_plan.push_back(plan_row(REQ_NONE_HI, '1, '1, HAND_CHECKED,
                                     40'd0, 40'd537122, 1'b0));
    directed_plan.push_back(plan_row(REQ_ADVANCE, '1, '1, MODEL_CHECKED,
                                     '0, '0, 1'b0));             // largest ms count
    directed_plan.push_back(plan_row(REQ_LOAD, '1, {1'b0, MAX_MINUTE - 40'd1}, HAND_CHECKED,
                                     40'd0, MAX_MINUTE - 40'd1, 1'b0));
    directed_plan.push_back(plan_row(REQ_STEP_MIN, 32'd1, 41'd0, HAND_CHECKED,
                                     40'd1, MAX_MINUTE, 1'b0));  // exact reach, no clamp
    directed_plan.push_back(plan_row(REQ_ADVANCE, 32'd60000, 41'd0, HAND_CHECKED,
                                     40'd0, MAX_MINUTE, 1'b0));  // advance at the ceiling
    directed_plan.push_back(plan_row(REQ_STEP_DAY, 32'd1, 41'd0, HAND_CHECKED,
                                     40'd0, MAX_MINUTE, 1'b0));  // step at the ceiling
    directed_plan.push_back(plan_row(REQ_LOAD, 32'd0, '1, HAND_CHECKED,
                                     40'd0, MAX_MINUTE, 1'b1));  // load far over the top
    directed_plan.push_back(plan_row(REQ_LOAD, '1, 41'd0, HAND_CHECKED,
                                     40'd0, 40'd0, 1'b0));       // load clears the flag
    directed_plan.push_back(plan_row(REQ_LOAD, 32'd0, {1'b0, MAX_MINUTE - 40'd10},
                                     HAND_CHECKED, 40'd0, MAX_MINUTE - 40'd10, 1'b0));
    directed_plan.push_back(plan_row(REQ_STEP_HOUR, 32'd1, 41'd0, HAND_CHECKED,
                                     40'd10, MAX_MINUTE, 1'b1)); // step cut at the ceiling
    directed_plan.push_back(plan_row(REQ_LOAD, 32'd0, {1'b1, 40'd0}, HAND_CHECKED,
                                     40'd0, MAX_MINUTE, 1'b1));  // one over the ceiling
    directed_plan.push_back(plan_row(REQ_LOAD, 32'd0, {1'b0, MAX_MINUTE - 40'd100},
                                     HAND_CHECKED, 40'd0, MAX_MINUTE - 40'd100, 1'b0));
    directed_plan.push_back(plan_row(REQ_ADVANCE, 32'd59999, 41'd0, MODEL_CHECKED,
                                     '0, '0, 1'b0));
    directed_plan.push_back(plan_row(REQ_ADVANCE, '1, 41'd0, MODEL_CHECKED,
                                     '0, '0, 1'b0));             // advance cut, credit cleared

    // synchronous reset held at the start, then released; requests may follow straight after
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct  = SEND_GAP_PCT[0];
    recv_stall_pct = RECV_STALL_PCT[0];
    foreach (directed_plan[i]) begin
      send_request(directed_plan[i].item, directed_plan[i].hand_checked,
                   directed_plan[i].want);
    end

    for (int s = 0; s < SETTINGS; s++) begin
      // registers change only with nothing in flight
      req_valid <= 1'b0;
      @(posedge clk);
      while (awaited_readings.size() != 0) begin
        @(posedge clk);
      end
      cfg_write(ADDR_MULT,     32'(CFG_PLAN[s].multiplier));
      cfg_write(ADDR_PAUSED,   32'(CFG_PLAN[s].paused));
      cfg_write(ADDR_LIM_MIN,  CFG_PLAN[s].max_step_minutes);
      cfg_write(ADDR_LIM_HOUR, CFG_PLAN[s].max_step_hours);
      cfg_write(ADDR_LIM_DAY,  CFG_PLAN[s].max_step_days);
      // read back: a refused rate must show the previous one
      cfg_read_check(ADDR_MULT,     32'(reg_mirror.multiplier));
      cfg_read_check(ADDR_PAUSED,   32'(reg_mirror.paused));
      cfg_read_check(ADDR_LIM_MIN,  reg_mirror.max_step_minutes);
      cfg_read_check(ADDR_LIM_HOUR, reg_mirror.max_step_hours);
      cfg_read_check(ADDR_LIM_DAY,  reg_mirror.max_step_days);

      // idling: slow receiver, then slow sender, then flat out
      send_idle_pct  = SEND_GAP_PCT[s / 2];
      recv_stall_pct = RECV_STALL_PCT[s / 2];
      repeat (ITEMS_PER_SETTING) begin
        send_request(random_request(), MODEL_CHECKED, '0);
      end
    end

    // drain, then leave room for any stray result behind the pipeline
    req_valid <= 1'b0;
    @(posedge clk);
    while (awaited_readings.size() != 0) begin
      @(posedge clk);
    end
    repeat (4 * PIPE_DEPTH) @(posedge clk);

    $display("covered %0d advance, %0d step, %0d load and %0d undefined-code transactions",
             n_advance, n_step, n_load, n_undefined);
    $display("over %0d register settings; %0d results checked, %0d at the minute ceiling",
             SETTINGS, readings_seen, ceiling_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
